[rtl/radar_measurement_jacobian_macros.svh]
// Assertion macros for the radar measurement Jacobian block.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RMJ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define RMJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rmj_pkg.sv]
// ---------------------------------------------------------------------------
// rmj_pkg
// Shared types and constants of the radar measurement Jacobian block.
// ---------------------------------------------------------------------------
package rmj_pkg;

	// Fixed-point format of state and result entries
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Reset value of the squared range threshold (about 1e-5 in 2^-32 units)
	localparam logic [31:0] MIN_RANGE_SQ_RST = 32'd42950;

	// Result lanes, one per Jacobian entry
	localparam int LANES         = 6;
	localparam int LN_RANGE_DX   = 0;
	localparam int LN_RANGE_DY   = 1;
	localparam int LN_BEARING_DX = 2;
	localparam int LN_BEARING_DY = 3;
	localparam int LN_RATE_DX    = 4;
	localparam int LN_RATE_DY    = 5;

	// Lanes whose magnitude is the square root of the quotient
	localparam logic [LANES-1:0] LANE_ROOT = 6'b110011;

	// Divider geometry: numerator, denominator and quotient widths
	localparam int NUM_W = 224;
	localparam int DEN_W = 190;
	localparam int QUO_W = 64;

	// Square root geometry
	localparam int ROOT_W = QUO_W / 2;
	localparam int SQR_W  = ROOT_W + 2;

	// Front-to-back queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef logic [DATA_WIDTH-1:0] mag_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] pos_x;
		logic signed [DATA_WIDTH-1:0] pos_y;
		logic signed [DATA_WIDTH-1:0] vel_x;
		logic signed [DATA_WIDTH-1:0] vel_y;
	} state_item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] range_dx;
		logic signed [DATA_WIDTH-1:0] range_dy;
		logic signed [DATA_WIDTH-1:0] bearing_dx;
		logic signed [DATA_WIDTH-1:0] bearing_dy;
		logic signed [DATA_WIDTH-1:0] rate_dx;
		logic signed [DATA_WIDTH-1:0] rate_dy;
		logic                         degenerate;
		logic                         saturated;
	} jac_item_t;

	// Sign/magnitude form of one state item
	typedef struct packed {
		mag_t px;
		mag_t py;
		mag_t vx;
		mag_t vy;
		logic npx;
		logic npy;
		logic nvx;
		logic nvy;
	} cls_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic avail;
	} qstat_t;

endpackage

[rtl/rmj_queue.sv]
// ---------------------------------------------------------------------------
// rmj_queue
// Small FIFO of classified items between the front and the back.
// ---------------------------------------------------------------------------
module rmj_queue import rmj_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cls_t   push_item,
	input  logic   pop,
	output cls_t   head,
	output qstat_t status
);

	cls_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_CW-1:0] cnt_q;

	// Storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head         = mem_q[rptr_q];
	assign status.full  = (cnt_q == Q_CW'(Q_DEPTH));
	assign status.avail = (cnt_q != '0);

endmodule

[rtl/rmj_front.sv]
// ---------------------------------------------------------------------------
// rmj_front
// Accepts state items and splits each field into sign and magnitude.
// ---------------------------------------------------------------------------
module rmj_front import rmj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        state_valid,
	output logic        state_stall,
	input  state_item_t state_item,
	input  qstat_t      qstat,
	output logic        push,
	output cls_t        push_item
);

	logic vld_s1;
	cls_t cls_s1;

	function automatic mag_t mag_of(logic [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? (mag_t'(0) - v) : v;
	endfunction

	// Hold the item while the queue is full
	assign state_stall = vld_s1 && qstat.full;
	assign push        = vld_s1 && !qstat.full;
	assign push_item   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!state_stall) begin
			vld_s1 <= state_valid;
		end
	end

	// Sign/magnitude split
	always_ff @(posedge clk) begin
		if (!state_stall && state_valid) begin
			cls_s1.px  <= mag_of(state_item.pos_x);
			cls_s1.py  <= mag_of(state_item.pos_y);
			cls_s1.vx  <= mag_of(state_item.vel_x);
			cls_s1.vy  <= mag_of(state_item.vel_y);
			cls_s1.npx <= state_item.pos_x[DATA_WIDTH-1];
			cls_s1.npy <= state_item.pos_y[DATA_WIDTH-1];
			cls_s1.nvx <= state_item.vel_x[DATA_WIDTH-1];
			cls_s1.nvy <= state_item.vel_y[DATA_WIDTH-1];
		end
	end

endmodule

[rtl/rmj_mul.sv]
// ---------------------------------------------------------------------------
// rmj_mul
// 128 x 64 unsigned multiplier from 32 x 32 partial products, three stages.
// ---------------------------------------------------------------------------
module rmj_mul import rmj_pkg::*; (
	input  logic         clk,
	input  logic         en,
	input  logic [127:0] a,
	input  logic [63:0]  b,
	output logic [191:0] prod
);

	logic [63:0]  pp_s1  [4][2];
	logic [159:0] row_s2 [2];
	logic [191:0] prod_s3;
	logic [159:0] row_sum [2];

	// Partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 2; j++) begin
					pp_s1[i][j] <= 64'(a[32*i +: 32]) * 64'(b[32*j +: 32]);
				end
			end
		end
	end

	// One row per limb of b
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			row_sum[j] = 160'(pp_s1[0][j]) + (160'(pp_s1[1][j]) << 32)
				+ (160'(pp_s1[2][j]) << 64) + (160'(pp_s1[3][j]) << 96);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2[0] <= row_sum[0];
			row_s2[1] <= row_sum[1];
			prod_s3   <= 192'(row_s2[0]) + (192'(row_s2[1]) << 32);
		end
	end

	assign prod = prod_s3;

endmodule

[rtl/rmj_back.sv]
// ---------------------------------------------------------------------------
// rmj_back
// Squares, cross term, range powers, per-entry division, square root and
// saturation, as one stall-together pipeline.
// ---------------------------------------------------------------------------
module rmj_back import rmj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] min_range_sq,
	input  cls_t        head,
	input  qstat_t      qstat,
	output logic        pop,
	output logic        jac_valid,
	input  logic        jac_stall,
	output jac_item_t   jac_item
);

	localparam int DIV_STEPS = QUO_W;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int SHIFT     = 2 * FRAC_BITS;
	localparam int MUL_LAT   = 3;
	localparam logic [QUO_W:0] LIM_NEG = (QUO_W+1)'(1) << (DATA_WIDTH - 1);
	localparam logic [QUO_W:0] LIM_POS = LIM_NEG - 1'b1;

	typedef struct packed {
		logic        deg;
		logic        np;
		logic        nq;
		logic        cneg;
		mag_t        p;
		mag_t        q;
		logic [63:0] p2;
		logic [63:0] q2;
		logic [63:0] r2;
	} hold_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [DEN_W-1:0] d;
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] nq;
	} lane_t;

	typedef struct packed {
		logic              neg;
		logic              ovf;
		logic [QUO_W-1:0]  x;
		logic [QUO_W-1:0]  rad;
		logic [SQR_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	logic        en;
	logic        vld_s1;
	cls_t        cls_s1;
	logic [63:0] p2_s1, q2_s1, a_s1, b_s1;
	logic        vld_s2;
	hold_t       hold_s2;
	logic [63:0] c_s2;
	hold_t       hold_nxt;
	logic [63:0] c_nxt;
	logic        sa, sb;

	logic        vld_ma [MUL_LAT];
	hold_t       hold_ma [MUL_LAT];
	logic        vld_mb [MUL_LAT];
	hold_t       hold_mb [MUL_LAT];
	logic [191:0] c2_prod, r4_prod, r6_prod, qc_prod, pc_prod;

	logic  vld_d [DIV_STEPS+1];
	logic  deg_d [DIV_STEPS+1];
	lane_t div_s [DIV_STEPS+1][LANES];
	lane_t div_init_lane [LANES];
	logic  vld_q [SQ_STEPS];
	logic  deg_q [SQ_STEPS];
	sq_t   sq_s  [SQ_STEPS][LANES];

	logic              vld_out_q;
	jac_item_t         jac_q;
	jac_item_t         jac_nxt;
	logic [DATA_WIDTH:0] res [LANES];
	logic [LANES-1:0]  sat_vec;

	function automatic lane_t div_init(logic [NUM_W-1:0] n, logic [DEN_W-1:0] d, logic neg);
		lane_t l;
		logic [NUM_W-QUO_W-1:0] top;
		top   = n[NUM_W-1:QUO_W];
		l.neg = neg;
		l.d   = d;
		l.ovf = (DEN_W'(top) >= d);
		l.rem = DEN_W'(top);
		l.nq  = n[QUO_W-1:0];
		return l;
	endfunction

	// One restoring division step; quotient bits replace numerator bits
	function automatic lane_t div_step(lane_t s);
		lane_t l;
		logic [DEN_W:0] r;
		l    = s;
		r    = {s.rem, s.nq[QUO_W-1]};
		l.nq = {s.nq[QUO_W-2:0], 1'b0};
		if (r >= {1'b0, s.d}) begin
			r       = r - {1'b0, s.d};
			l.nq[0] = 1'b1;
		end
		l.rem = r[DEN_W-1:0];
		return l;
	endfunction

	function automatic sq_t sq_from(lane_t l);
		sq_t s;
		s.neg  = l.neg;
		s.ovf  = l.ovf;
		s.x    = l.nq;
		s.rad  = l.nq;
		s.rem  = '0;
		s.root = '0;
		return s;
	endfunction

	// One digit of the integer square root
	function automatic sq_t sq_step(sq_t s);
		sq_t o;
		logic [SQR_W+1:0] r;
		logic [SQR_W+1:0] t;
		o     = s;
		r     = {s.rem, s.rad[QUO_W-1 -: 2]};
		t     = {2'b00, s.root, 2'b01};
		o.rad = {s.rad[QUO_W-3:0], 2'b00};
		if (r >= t) begin
			r      = r - t;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		o.rem = r[SQR_W-1:0];
		return o;
	endfunction

	// Clip to the signed range and apply the sign; top bit is the clip flag
	function automatic logic [DATA_WIDTH:0] emit(sq_t s, logic is_root);
		logic [QUO_W:0]      m;
		logic [QUO_W:0]      lim;
		logic                sat;
		logic [DATA_WIDTH-1:0] v;
		if (s.ovf)        m = '1;
		else if (is_root) m = (QUO_W+1)'(s.root);
		else              m = (QUO_W+1)'(s.x);
		lim = s.neg ? LIM_NEG : LIM_POS;
		sat = 1'b0;
		if (m > lim) begin
			m   = lim;
			sat = 1'b1;
		end
		v = s.neg ? (DATA_WIDTH'(0) - m[DATA_WIDTH-1:0]) : m[DATA_WIDTH-1:0];
		return {sat, v};
	endfunction

	// Whole pipeline moves unless a finished item is held at the output
	assign en  = !vld_out_q || !jac_stall;
	assign pop = en && qstat.avail;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_out_q <= 1'b0;
			for (int i = 0; i < MUL_LAT; i++) begin
				vld_ma[i] <= 1'b0;
				vld_mb[i] <= 1'b0;
			end
			for (int i = 0; i <= DIV_STEPS; i++) vld_d[i] <= 1'b0;
			for (int i = 0; i < SQ_STEPS; i++)   vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_s1    <= qstat.avail;
			vld_s2    <= vld_s1;
			vld_ma[0] <= vld_s2;
			vld_mb[0] <= vld_ma[MUL_LAT-1];
			for (int i = 1; i < MUL_LAT; i++) begin
				vld_ma[i] <= vld_ma[i-1];
				vld_mb[i] <= vld_mb[i-1];
			end
			vld_d[0] <= vld_mb[MUL_LAT-1];
			for (int i = 1; i <= DIV_STEPS; i++) vld_d[i] <= vld_d[i-1];
			vld_q[0] <= vld_d[DIV_STEPS];
			for (int i = 1; i < SQ_STEPS; i++) vld_q[i] <= vld_q[i-1];
			vld_out_q <= vld_q[SQ_STEPS-1];
		end
	end

	// Stage 1: squares and cross products
	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1 <= head;
			p2_s1  <= 64'(head.px) * 64'(head.px);
			q2_s1  <= 64'(head.py) * 64'(head.py);
			a_s1   <= 64'(head.vx) * 64'(head.py);
			b_s1   <= 64'(head.vy) * 64'(head.px);
		end
	end

	// Stage 2: squared range, threshold, signed cross term
	always_comb begin
		sa            = cls_s1.nvx ^ cls_s1.npy;
		sb            = cls_s1.nvy ^ cls_s1.npx;
		hold_nxt.np   = cls_s1.npx;
		hold_nxt.nq   = cls_s1.npy;
		hold_nxt.p    = cls_s1.px;
		hold_nxt.q    = cls_s1.py;
		hold_nxt.p2   = p2_s1;
		hold_nxt.q2   = q2_s1;
		hold_nxt.r2   = p2_s1 + q2_s1;
		hold_nxt.deg  = (hold_nxt.r2 == '0) || (hold_nxt.r2 < 64'(min_range_sq));
		if (sa == sb) begin
			if (a_s1 >= b_s1) begin
				c_nxt         = a_s1 - b_s1;
				hold_nxt.cneg = sa;
			end else begin
				c_nxt         = b_s1 - a_s1;
				hold_nxt.cneg = !sa;
			end
		end else begin
			c_nxt         = a_s1 + b_s1;
			hold_nxt.cneg = sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hold_s2 <= hold_nxt;
			c_s2    <= c_nxt;
		end
	end

	// First multiply round: c^2 and r2^2
	rmj_mul u_mul_c2 (.clk(clk), .en(en), .a({64'b0, c_s2}), .b(c_s2), .prod(c2_prod));
	rmj_mul u_mul_r4 (
		.clk(clk), .en(en), .a({64'b0, hold_s2.r2}), .b(hold_s2.r2), .prod(r4_prod)
	);

	// Second multiply round: r2^3, q2*c^2, p2*c^2
	rmj_mul u_mul_r6 (
		.clk(clk), .en(en), .a(r4_prod[127:0]), .b(hold_ma[MUL_LAT-1].r2), .prod(r6_prod)
	);
	rmj_mul u_mul_qc (
		.clk(clk), .en(en), .a(c2_prod[127:0]), .b(hold_ma[MUL_LAT-1].q2), .prod(qc_prod)
	);
	rmj_mul u_mul_pc (
		.clk(clk), .en(en), .a(c2_prod[127:0]), .b(hold_ma[MUL_LAT-1].p2), .prod(pc_prod)
	);

	// Side data riding along the multipliers
	always_ff @(posedge clk) begin
		if (en) begin
			hold_ma[0] <= hold_s2;
			hold_mb[0] <= hold_ma[MUL_LAT-1];
			for (int i = 1; i < MUL_LAT; i++) begin
				hold_ma[i] <= hold_ma[i-1];
				hold_mb[i] <= hold_mb[i-1];
			end
		end
	end

	// Divider setup for the six entries
	always_comb begin
		div_init_lane[LN_RANGE_DX] = div_init(NUM_W'(hold_mb[MUL_LAT-1].p2) << SHIFT,
			DEN_W'(hold_mb[MUL_LAT-1].r2), hold_mb[MUL_LAT-1].np);
		div_init_lane[LN_RANGE_DY] = div_init(NUM_W'(hold_mb[MUL_LAT-1].q2) << SHIFT,
			DEN_W'(hold_mb[MUL_LAT-1].r2), hold_mb[MUL_LAT-1].nq);
		div_init_lane[LN_BEARING_DX] = div_init(NUM_W'(hold_mb[MUL_LAT-1].q) << SHIFT,
			DEN_W'(hold_mb[MUL_LAT-1].r2), !hold_mb[MUL_LAT-1].nq);
		div_init_lane[LN_BEARING_DY] = div_init(NUM_W'(hold_mb[MUL_LAT-1].p) << SHIFT,
			DEN_W'(hold_mb[MUL_LAT-1].r2), hold_mb[MUL_LAT-1].np);
		div_init_lane[LN_RATE_DX] = div_init(NUM_W'(qc_prod) << SHIFT,
			r6_prod[DEN_W-1:0], hold_mb[MUL_LAT-1].nq ^ hold_mb[MUL_LAT-1].cneg);
		div_init_lane[LN_RATE_DY] = div_init(NUM_W'(pc_prod) << SHIFT,
			r6_prod[DEN_W-1:0], hold_mb[MUL_LAT-1].np ^ !hold_mb[MUL_LAT-1].cneg);
	end

	// Division and square root stages
	always_ff @(posedge clk) begin
		if (en) begin
			deg_d[0] <= hold_mb[MUL_LAT-1].deg;
			for (int l = 0; l < LANES; l++) div_s[0][l] <= div_init_lane[l];
			for (int i = 1; i <= DIV_STEPS; i++) begin
				deg_d[i] <= deg_d[i-1];
				for (int l = 0; l < LANES; l++) div_s[i][l] <= div_step(div_s[i-1][l]);
			end
			deg_q[0] <= deg_d[DIV_STEPS];
			for (int l = 0; l < LANES; l++) begin
				sq_s[0][l] <= sq_step(sq_from(div_s[DIV_STEPS][l]));
			end
			for (int i = 1; i < SQ_STEPS; i++) begin
				deg_q[i] <= deg_q[i-1];
				for (int l = 0; l < LANES; l++) sq_s[i][l] <= sq_step(sq_s[i-1][l]);
			end
		end
	end

	// Output: clip, sign, degenerate override
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			res[l]     = emit(sq_s[SQ_STEPS-1][l], LANE_ROOT[l]);
			sat_vec[l] = res[l][DATA_WIDTH];
		end
		jac_nxt.range_dx   = res[LN_RANGE_DX][DATA_WIDTH-1:0];
		jac_nxt.range_dy   = res[LN_RANGE_DY][DATA_WIDTH-1:0];
		jac_nxt.bearing_dx = res[LN_BEARING_DX][DATA_WIDTH-1:0];
		jac_nxt.bearing_dy = res[LN_BEARING_DY][DATA_WIDTH-1:0];
		jac_nxt.rate_dx    = res[LN_RATE_DX][DATA_WIDTH-1:0];
		jac_nxt.rate_dy    = res[LN_RATE_DY][DATA_WIDTH-1:0];
		jac_nxt.degenerate = 1'b0;
		jac_nxt.saturated  = |sat_vec;
		if (deg_q[SQ_STEPS-1]) begin
			jac_nxt            = '0;
			jac_nxt.degenerate = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			jac_q <= jac_nxt;
		end
	end

	assign jac_valid = vld_out_q;
	assign jac_item  = jac_q;

endmodule

[rtl/radar_measurement_jacobian.sv]
// Throughput: one item per cycle while the output is not stalled; the back pipeline has one
// stage per quotient bit (64) and per root bit (32), plus squaring and two multiplier rounds.
// A 4-entry queue lets the input keep taking items while the output is stalled, until it fills.
// Reset (arst_n low, asynchronous) empties the pipeline and queue and sets the
// threshold to 42950.
// ---------------------------------------------------------------------------
// radar_measurement_jacobian
// Jacobian of the Cartesian-to-polar radar measurement for one tracked state.
// ---------------------------------------------------------------------------
module radar_measurement_jacobian import rmj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        state_valid,
	output logic        state_stall,
	input  state_item_t state_item,
	output logic        jac_valid,
	input  logic        jac_stall,
	output jac_item_t   jac_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] min_range_sq_q;
	logic        push;
	logic        pop;
	cls_t        push_item;
	cls_t        head;
	qstat_t      qstat;

	// Threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_sq_q <= MIN_RANGE_SQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_range_sq_q <= cfg_data;
		end
	end

	rmj_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.state_valid (state_valid),
		.state_stall (state_stall),
		.state_item  (state_item),
		.qstat       (qstat),
		.push        (push),
		.push_item   (push_item)
	);

	rmj_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (qstat)
	);

	rmj_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.min_range_sq (min_range_sq_q),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.jac_valid    (jac_valid),
		.jac_stall    (jac_stall),
		.jac_item     (jac_item)
	);

endmodule

[rtl/rmj_checker.sv]
// ---------------------------------------------------------------------------
// rmj_checker
// Port-level checks on the Jacobian block, bound to the top level.
// ---------------------------------------------------------------------------
`include "radar_measurement_jacobian_macros.svh"

module rmj_checker import rmj_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      jac_valid,
	input logic      jac_stall,
	input jac_item_t jac_item,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	// A stalled result holds
	`RMJ_ASSERT_NEXT(a_jac_hold, jac_valid && jac_stall, jac_valid && $stable(jac_item), "result changed while stalled")

	// Degenerate items carry all-zero entries and no clip flag
	`RMJ_ASSERT_NOW(a_deg_zero, jac_valid && jac_item.degenerate, !jac_item.saturated && jac_item.range_dx == '0 && jac_item.range_dy == '0 && jac_item.bearing_dx == '0 && jac_item.bearing_dy == '0 && jac_item.rate_dx == '0 && jac_item.rate_dy == '0, "degenerate item not zeroed")

	// Range entries stay within one in magnitude
	`RMJ_ASSERT_NOW(a_range_unit, jac_valid, jac_item.range_dx <= 32'sd65536 && jac_item.range_dx >= -32'sd65536 && jac_item.range_dy <= 32'sd65536 && jac_item.range_dy >= -32'sd65536, "range entry exceeds one")

	// Threshold writes are always taken
	`RMJ_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "threshold write refused")

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (.*);

[bench/tb_radar_measurement_jacobian.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_radar_measurement_jacobian
// Self-checking bench for the radar measurement Jacobian block. State items
// come from a queue, directed first and then random, across several range
// thresholds. Each accepted item is scored against a wide-integer predictor
// of the exact, truncated and saturated Jacobian entries.
// ---------------------------------------------------------------------------
module tb_radar_measurement_jacobian;
	import rmj_pkg::*;

	typedef logic [255:0] wide_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 130;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        state_valid = 1'b0;
	logic        state_stall;
	state_item_t state_item = '0;
	logic        jac_valid;
	logic        jac_stall = 1'b0;
	jac_item_t   jac_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	state_item_t pending_states[$];
	jac_item_t   expected_jacs[$];
	logic [31:0] range_floor = MIN_RANGE_SQ_RST;
	logic        took = 1'b0;
	logic        calm = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int          n_errors = 0;
	int          n_results = 0;
	int          n_degenerate = 0;
	int          n_saturated = 0;

	radar_measurement_jacobian dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.state_valid(state_valid),
		.state_stall(state_stall),
		.state_item (state_item),
		.jac_valid  (jac_valid),
		.jac_stall  (jac_stall),
		.jac_item   (jac_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Integer square root, floor
	function automatic wide_t isqrt(wide_t x);
		wide_t r, t;
		r = '0;
		for (int i = 127; i >= 0; i--) begin
			t = r | (wide_t'(1) << i);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	// Signed entry from a magnitude: {clipped, value}
	function automatic logic [32:0] clip_entry(wide_t m, logic neg);
		wide_t lim;
		logic  hit;
		lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
		hit = (m > lim);
		if (hit)
			m = lim;
		return {hit, neg ? -m[31:0] : m[31:0]};
	endfunction

	// Exact Jacobian entries of one state item
	function automatic jac_item_t jacobian_of(state_item_t s, logic [31:0] thr);
		jac_item_t  j;
		wide_t      p, q, vx, vy, p2, q2, r2, r3, a, b, c, c2;
		logic       np, nq, nvx, nvy, sa, sb, cneg;
		logic [32:0] e [LANES];
		np  = s.pos_x[31];
		nq  = s.pos_y[31];
		nvx = s.vel_x[31];
		nvy = s.vel_y[31];
		// magnitudes, zero-extended so that the most negative value gives 2^31
		p  = wide_t'($unsigned(np  ? -s.pos_x : s.pos_x));
		q  = wide_t'($unsigned(nq  ? -s.pos_y : s.pos_y));
		vx = wide_t'($unsigned(nvx ? -s.vel_x : s.vel_x));
		vy = wide_t'($unsigned(nvy ? -s.vel_y : s.vel_y));
		p2 = p * p;
		q2 = q * q;
		r2 = p2 + q2;
		j = '0;
		if (r2 == 0 || r2 < wide_t'(thr)) begin
			j.degenerate = 1'b1;
			return j;
		end
		// cross term vx*py - vy*px in sign/magnitude
		a  = vx * q;
		sa = nvx ^ nq;
		b  = vy * p;
		sb = nvy ^ np;
		if (sa == sb) begin
			if (a >= b) begin
				c = a - b;
				cneg = sa;
			end else begin
				c = b - a;
				cneg = !sa;
			end
		end else begin
			c = a + b;
			cneg = sa;
		end
		c2 = c * c;
		r3 = r2 * r2 * r2;
		e[LN_RANGE_DX]   = clip_entry(isqrt((p2 << 32) / r2), np);
		e[LN_RANGE_DY]   = clip_entry(isqrt((q2 << 32) / r2), nq);
		e[LN_BEARING_DX] = clip_entry((q << 32) / r2, !nq);
		e[LN_BEARING_DY] = clip_entry((p << 32) / r2, np);
		e[LN_RATE_DX]    = clip_entry(isqrt(((q2 * c2) << 32) / r3), nq ^ cneg);
		e[LN_RATE_DY]    = clip_entry(isqrt(((p2 * c2) << 32) / r3), np ^ !cneg);
		j.range_dx   = e[LN_RANGE_DX][31:0];
		j.range_dy   = e[LN_RANGE_DY][31:0];
		j.bearing_dx = e[LN_BEARING_DX][31:0];
		j.bearing_dy = e[LN_BEARING_DY][31:0];
		j.rate_dx    = e[LN_RATE_DX][31:0];
		j.rate_dy    = e[LN_RATE_DY][31:0];
		for (int i = 0; i < LANES; i++)
			j.saturated |= e[i][32];
		return j;
	endfunction

	// Random value scaled down by a random shift, sign kept
	function automatic logic [31:0] scaled_rand(int lo_shift, int hi_shift);
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(lo_shift, hi_shift);
	endfunction

	// Random state mix: full range, moderate, near-origin and on-axis
	function automatic state_item_t random_state();
		state_item_t s;
		int          kind;
		kind = $urandom_range(0, 9);
		s.vel_x = $urandom;
		s.vel_y = $urandom;
		case (kind)
			0, 1, 2: begin
				s.pos_x = $urandom;
				s.pos_y = $urandom;
			end
			3, 4, 5: begin
				s.pos_x = scaled_rand(8, 20);
				s.pos_y = scaled_rand(8, 20);
				s.vel_x = scaled_rand(4, 20);
				s.vel_y = scaled_rand(4, 20);
			end
			6, 7: begin
				s.pos_x = scaled_rand(22, 31);
				s.pos_y = scaled_rand(22, 31);
			end
			default: begin
				s.pos_x = ($urandom_range(0, 1) != 0) ? 32'(scaled_rand(0, 20)) : '0;
				s.pos_y = (s.pos_x == 0) ? 32'(scaled_rand(0, 20)) : '0;
			end
		endcase
		return s;
	endfunction

	function automatic state_item_t make_state(logic [31:0] px, logic [31:0] py,
			logic [31:0] vx, logic [31:0] vy);
		state_item_t s;
		s.pos_x = px;
		s.pos_y = py;
		s.vel_x = vx;
		s.vel_y = vy;
		return s;
	endfunction

	// Wait until the block is drained, then write the range threshold
	task automatic set_range_floor(logic [31:0] value);
		wait (pending_states.size() == 0 && expected_jacs.size() == 0 && !state_valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		range_floor = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// State driver
	always @(negedge clk) begin
		if (arst_n && (!state_valid || took)) begin
			if (!calm && send_gap == 0 && $urandom_range(0, 7) == 0)
				send_gap = $urandom_range(1, 4);
			if (send_gap > 0) begin
				send_gap--;
				state_valid <= 1'b0;
			end else if (pending_states.size() != 0) begin
				state_item  <= pending_states.pop_front();
				state_valid <= 1'b1;
			end else begin
				state_valid <= 1'b0;
			end
		end
	end

	// Result stall in bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (!calm && stall_left == 0 && $urandom_range(0, 6) == 0)
				stall_left = $urandom_range(1, 4);
			if (stall_left > 0) begin
				stall_left--;
				jac_stall <= 1'b1;
			end else begin
				jac_stall <= 1'b0;
			end
		end
	end

	// Prediction on input accept, scoring on output accept, watchdog
	always @(posedge clk) begin
		jac_item_t want;
		if (arst_n) begin
			took <= state_valid && !state_stall;
			if (state_valid && !state_stall)
				expected_jacs.push_back(jacobian_of(state_item, range_floor));
			if (jac_valid && !jac_stall) begin
				n_results++;
				if (expected_jacs.size() == 0) begin
					$error("unexpected Jacobian item");
					n_errors++;
				end else begin
					want = expected_jacs.pop_front();
					n_degenerate += want.degenerate;
					n_saturated  += want.saturated;
					if (jac_item.range_dx !== want.range_dx) begin
						$error("range_dx: expected %0d, got %0d", want.range_dx, jac_item.range_dx);
						n_errors++;
					end
					if (jac_item.range_dy !== want.range_dy) begin
						$error("range_dy: expected %0d, got %0d", want.range_dy, jac_item.range_dy);
						n_errors++;
					end
					if (jac_item.bearing_dx !== want.bearing_dx) begin
						$error("bearing_dx: expected %0d, got %0d",
							want.bearing_dx, jac_item.bearing_dx);
						n_errors++;
					end
					if (jac_item.bearing_dy !== want.bearing_dy) begin
						$error("bearing_dy: expected %0d, got %0d",
							want.bearing_dy, jac_item.bearing_dy);
						n_errors++;
					end
					if (jac_item.rate_dx !== want.rate_dx) begin
						$error("rate_dx: expected %0d, got %0d", want.rate_dx, jac_item.rate_dx);
						n_errors++;
					end
					if (jac_item.rate_dy !== want.rate_dy) begin
						$error("rate_dy: expected %0d, got %0d", want.rate_dy, jac_item.rate_dy);
						n_errors++;
					end
					if (jac_item.degenerate !== want.degenerate) begin
						$error("degenerate: expected %0b, got %0b",
							want.degenerate, jac_item.degenerate);
						n_errors++;
					end
					if (jac_item.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b",
							want.saturated, jac_item.saturated);
						n_errors++;
					end
				end
			end
			if ((state_valid && !state_stall) || (jac_valid && !jac_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin
		logic [31:0] floors [5];
		logic [31:0] one;
		logic [31:0] maxv;
		logic [31:0] minv;
		one  = 32'h0001_0000;
		maxv = 32'h7fff_ffff;
		minv = 32'h8000_0000;
		floors[0] = 32'd0;
		floors[1] = 32'hffff_ffff;
		floors[2] = $urandom;
		floors[3] = 32'd1;
		floors[4] = MIN_RANGE_SQ_RST;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset threshold
		pending_states.push_back(make_state('0, '0, '0, '0));
		pending_states.push_back(make_state(maxv, maxv, maxv, maxv));
		pending_states.push_back(make_state(minv, minv, minv, minv));
		pending_states.push_back(make_state(maxv, minv, minv, maxv));
		pending_states.push_back(make_state(minv, '0, maxv, minv));
		pending_states.push_back(make_state('0, maxv, minv, maxv));
		pending_states.push_back(make_state(one, '0, '0, one));
		pending_states.push_back(make_state('0, -one, one, '0));
		pending_states.push_back(make_state(one, one, one, one));
		pending_states.push_back(make_state(one, -one, -one, one));
		pending_states.push_back(make_state(32'd1, 32'd1, maxv, minv));
		pending_states.push_back(make_state(32'd207, '0, one, one));
		pending_states.push_back(make_state(32'd208, '0, one, one));
		pending_states.push_back(make_state(-32'd150, 32'd150, maxv, maxv));
		pending_states.push_back(make_state(32'd3, -32'd4, minv, maxv));
		pending_states.push_back(make_state(32'd1024, 32'd1, maxv, minv));
		pending_states.push_back(make_state(-one, -one, one, -one));
		pending_states.push_back(make_state(32'h0000_0100, 32'h0000_0100, maxv, '0));
		pending_states.push_back(make_state(32'hffff_ffff, '0, '0, '0));

		// Phases over several thresholds, each starting from an idle block
		for (int ph = 0; ph < 5; ph++) begin
			set_range_floor(floors[ph]);
			if (ph == 4)
				calm = 1'b1;
			for (int k = 0; k < 216; k++)
				pending_states.push_back(random_state());
		end

		wait (pending_states.size() == 0 && expected_jacs.size() == 0 && !state_valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d Jacobian items over 6 range thresholds", n_results);
		$display("%0d degenerate and %0d saturated results seen", n_degenerate, n_saturated);
		if (n_errors == 0 && expected_jacs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
